FILE: src/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Used by ils_mem, ils_seq, indexed_list_store and ils_checker; no dependencies.
package ils_pkg;

  // widest memory address, wide enough for a capacity of up to 4096 entries
  localparam int unsigned MaxAddrW = 12;
  localparam int unsigned DataW    = 32;
  localparam int unsigned TotalW   = 7;

  // request codes carried on func
  localparam logic [2:0] FnRead     = 3'd0;
  localparam logic [2:0] FnInsFront = 3'd1;
  localparam logic [2:0] FnInsEnd   = 3'd2;
  localparam logic [2:0] FnInsPos   = 3'd3;
  localparam logic [2:0] FnDelete   = 3'd4;

  // status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // one cycle of memory traffic: at most one write and one read
  typedef struct packed {
    logic                we;
    logic [MaxAddrW-1:0] waddr;
    logic [DataW-1:0]    wdata;
    logic                re;
    logic [MaxAddrW-1:0] raddr;
  } mem_req_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]              status;
    logic [TotalW-1:0]       element_total;
  } res_t;

endpackage

FILE: src/ils_mem.sv
// Element storage: one write port and one read port with registered read data.
// Depends on ils_pkg for the request type.
module ils_mem
  import ils_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AddrW-1:0]] <= req_i.wdata;
    end
  end

  // read port, registered, holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AddrW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ils_seq.sv
// Request sequencer: decodes a request, walks the memory to open or close a gap,
// keeps the element count and produces one result. Depends on ils_pkg.
module ils_seq
  import ils_pkg::*;
#(
  parameter int unsigned Capacity = 64,
  parameter int unsigned AddrW    = 6,
  parameter int unsigned CountW   = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       func_i,
  input  logic [6:0]       position_i,
  input  logic [DataW-1:0] item_value_i,
  output mem_req_t         mem_req_o,
  input  logic [DataW-1:0] mem_rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int unsigned CmpW = (CountW > 7) ? CountW : 7;

  typedef enum logic [2:0] {
    SIdle,
    SInsShift,
    SInsLast,
    SInsPut,
    SDelShift,
    SDelLast,
    SFin
  } state_e;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [AddrW-1:0]        ptr_q, ptr_d;
  logic [AddrW-1:0]        wptr_q, wptr_d;
  logic                    pend_q, pend_d;
  logic [AddrW-1:0]        pos_q, pos_d;
  logic [DataW-1:0]        val_q, val_d;
  logic signed [DataW-1:0] rv_q, rv_d;
  logic [1:0]              st_q, st_d;
  logic                    use_rd_q, use_rd_d;

  logic [CmpW-1:0]  pos_x, cnt_x;
  logic             pos_lt, pos_gt, full;
  logic [AddrW-1:0] pos_a, cnt_a, last_a, tgt;
  mem_req_t         req;

  // position checks against the current count
  assign pos_x  = CmpW'(position_i);
  assign cnt_x  = CmpW'(count_q);
  assign pos_lt = pos_x < cnt_x;
  assign pos_gt = pos_x > cnt_x;
  assign full   = count_q == CountW'(Capacity);
  assign pos_a  = AddrW'(position_i);
  assign cnt_a  = AddrW'(count_q);
  assign last_a = cnt_a - AddrW'(1);

  // next state and memory traffic
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    wptr_d   = wptr_q;
    pend_d   = pend_q;
    pos_d    = pos_q;
    val_d    = val_q;
    rv_d     = rv_q;
    st_d     = st_q;
    use_rd_d = use_rd_q;
    tgt      = '0;
    req      = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          val_d    = item_value_i;
          pos_d    = pos_a;
          rv_d     = '0;
          st_d     = StOk;
          use_rd_d = 1'b0;
          pend_d   = 1'b0;
          state_d  = SFin;
          case (func_i) inside
            FnRead: begin
              if (pos_lt) begin
                req.re   = 1'b1;
                req.raddr = MaxAddrW'(pos_a);
                use_rd_d = 1'b1;
              end else begin
                rv_d = '1;
                st_d = StRange;
              end
            end
            FnInsFront, FnInsEnd, FnInsPos: begin
              if (full) begin
                st_d = StFull;
              end else if (func_i == FnInsPos && pos_gt) begin
                rv_d = '1;
                st_d = StRange;
              end else begin
                if (func_i == FnInsFront) begin
                  tgt = '0;
                end else if (func_i == FnInsEnd) begin
                  tgt = cnt_a;
                end else begin
                  tgt = pos_a;
                end
                pos_d = tgt;
                if (tgt == cnt_a) begin
                  // append: no entries move
                  req.we    = 1'b1;
                  req.waddr = MaxAddrW'(tgt);
                  req.wdata = item_value_i;
                  count_d   = count_q + CountW'(1);
                end else begin
                  ptr_d   = last_a;
                  state_d = SInsShift;
                end
              end
            end
            FnDelete: begin
              if (!pos_lt) begin
                rv_d = '1;
                st_d = StRange;
              end else if (pos_a == last_a) begin
                count_d = count_q - CountW'(1);
              end else begin
                ptr_d   = pos_a + AddrW'(1);
                state_d = SDelShift;
              end
            end
            default: begin
              st_d = StRange;
            end
          endcase
        end
      end
      // read one slot down, write the previous read one slot up
      SInsShift: begin
        req.re    = 1'b1;
        req.raddr = MaxAddrW'(ptr_q);
        req.we    = pend_q;
        req.waddr = MaxAddrW'(wptr_q);
        req.wdata = mem_rdata_i;
        pend_d    = 1'b1;
        wptr_d    = ptr_q + AddrW'(1);
        if (ptr_q == pos_q) begin
          state_d = SInsLast;
        end else begin
          ptr_d = ptr_q - AddrW'(1);
        end
      end
      SInsLast: begin
        req.we    = 1'b1;
        req.waddr = MaxAddrW'(wptr_q);
        req.wdata = mem_rdata_i;
        state_d   = SInsPut;
      end
      SInsPut: begin
        req.we    = 1'b1;
        req.waddr = MaxAddrW'(pos_q);
        req.wdata = val_q;
        count_d   = count_q + CountW'(1);
        state_d   = SFin;
      end
      // read one slot up, write the previous read one slot down
      SDelShift: begin
        req.re    = 1'b1;
        req.raddr = MaxAddrW'(ptr_q);
        req.we    = pend_q;
        req.waddr = MaxAddrW'(wptr_q);
        req.wdata = mem_rdata_i;
        pend_d    = 1'b1;
        wptr_d    = ptr_q - AddrW'(1);
        if (ptr_q == last_a) begin
          state_d = SDelLast;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      SDelLast: begin
        req.we    = 1'b1;
        req.waddr = MaxAddrW'(wptr_q);
        req.wdata = mem_rdata_i;
        count_d   = count_q - CountW'(1);
        state_d   = SFin;
      end
      SFin: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // state and registered request fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      count_q  <= '0;
      pend_q   <= 1'b0;
      use_rd_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      use_rd_q <= use_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    wptr_q <= wptr_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    rv_q   <= rv_d;
    st_q   <= st_d;
  end

  assign in_ready_o  = state_q == SIdle;
  assign mem_req_o   = req;
  assign res_valid_o = state_q == SFin;

  // result fields, read data taken straight from the memory port
  always_comb begin
    res_o.read_value    = use_rd_q ? mem_rdata_i : rv_q;
    res_o.status        = st_q;
    res_o.element_total = TotalW'(count_q);
  end

endmodule

FILE: src/indexed_list_store.sv
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit values in one
// synchronous memory, serving read, insert front, insert end, insert at position and
// delete at position, one request at a time with one result per request. A read, an
// append or a rejected request moves no entries; an insert at position p moves the
// entries from p onward up one slot and a delete at p moves the entries behind p down
// one slot, each through the single memory read port and write port one entry per
// cycle; a delete of the last entry moves none. The result sits in an output register,
// so a new request is taken while the previous result waits.
// Depends on ils_pkg, ils_seq and ils_mem.
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              func_i,
  input  logic [6:0]              position_i,
  input  logic signed [31:0]      item_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [31:0]      read_value_o,
  output logic [1:0]              status_o,
  output logic [6:0]              element_total_o
);

  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  ils_seq #(
    .Capacity(CAPACITY),
    .AddrW   (AddrW),
    .CountW  (CountW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ils_mem #(
    .Depth(CAPACITY),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  // output register, loaded when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = out_q.read_value;
  assign status_o        = out_q.status;
  assign element_total_o = out_q.element_total;

endmodule

FILE: src/ils_checker.sv
// Port-level checks for indexed_list_store, attached by the bind at the end.
// Depends on ils_pkg for the status codes.
module ils_checker
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] read_value_o,
  input logic [1:0]         status_o,
  input logic [6:0]         element_total_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(status_o) && $stable(element_total_o))
    else $error("result changed while stalled");

  // only defined status codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StOk || status_o == StRange || status_o == StFull)
    else $error("undefined status code");

  // a refused insert reports a full list and no read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StFull |->
      element_total_o == 7'(CAPACITY) && read_value_o == 32'sd0)
    else $error("full status with wrong total or value");

  // a rejected request carries all ones or zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StRange |-> read_value_o == -32'sd1 || read_value_o == 32'sd0)
    else $error("out of range result with read data");

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);
